[rtl/core/bpfm_pkg.sv]
package bpfm_pkg;

    localparam int PREFIX_BYTES = 8;
    localparam int MAX_ENTRIES  = 8;
    localparam int MAX_NAME_LEN = 64;

    localparam int BYTE_VALUES = 256;
    localparam int KEY_LEN_MAX = 127;

    localparam int FUNC_W  = 2;
    localparam int ENTRY_W = 3;
    localparam int POS_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;

    // Bitmap memory: one row per byte value, holding every prefix position's entry mask.
    localparam int BM_ROW_W = PREFIX_BYTES * MAX_ENTRIES;
    localparam int BM_AW    = $clog2(BYTE_VALUES);
    // Name memory: one row per byte position, holding that byte of every entry.
    localparam int NM_ROW_W = MAX_ENTRIES * BYTE_W;
    localparam int NM_AW    = $clog2(MAX_NAME_LEN);

    typedef logic [FUNC_W-1:0] func_t;
    localparam func_t FUNC_CLEAR = 2'd0;
    localparam func_t FUNC_LOAD  = 2'd1;
    localparam func_t FUNC_KEY   = 2'd2;

    typedef logic [LEN_W-1:0] len_t;
    typedef logic [MAX_ENTRIES-1:0] mask_t;

    typedef struct packed {
        logic               rd_en;
        logic [BM_AW-1:0]   bm_addr;
        logic [NM_AW-1:0]   nm_addr;
    } store_rd_t;

    typedef struct packed {
        logic               clear;
        logic               load;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   position;
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
    } store_wr_t;

endpackage

[rtl/core/bpfm_in_if.sv]
interface bpfm_in_if
    import bpfm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [ENTRY_W-1:0]   entry;
    logic [POS_W-1:0]     position;
    logic [BYTE_W-1:0]    data_byte;
    logic                 last;

    modport source (output valid, func, entry, position, data_byte, last, input ready);
    modport sink   (input valid, func, entry, position, data_byte, last, output ready);
endinterface

[rtl/core/bpfm_out_if.sv]
interface bpfm_out_if
    import bpfm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [ENTRY_W-1:0] field_index;

    modport source (output valid, found, field_index, input ready);
    modport sink   (input valid, found, field_index, output ready);
endinterface

[rtl/core/bpfm_ram.sv]
module bpfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/bpfm_store.sv]
module bpfm_store
    import bpfm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  store_rd_t                  rd,
    input  store_wr_t                  wr,
    output logic [BM_ROW_W-1:0]        bm_row,
    output logic [NM_ROW_W-1:0]        nm_row,
    output len_t [MAX_ENTRIES-1:0]     name_len
);

    logic [BYTE_VALUES-1:0]    bm_valid_reg;
    logic [BM_AW-1:0]          bm_addr_reg;
    len_t [MAX_ENTRIES-1:0]    name_len_reg;

    logic [BM_ROW_W-1:0]       bm_rdata;
    logic [BM_ROW_W-1:0]       bm_wdata;
    logic [NM_ROW_W-1:0]       nm_wdata;
    logic                      entry_ok;
    logic                      pos_ok;
    logic                      in_prefix;
    logic                      bm_we;
    logic                      nm_we;

    // A bitmap row that has not been written since the last clear reads as zero.
    assign bm_row   = bm_valid_reg[bm_addr_reg] ? bm_rdata : '0;
    assign name_len = name_len_reg;

    assign entry_ok  = int'(wr.entry) < MAX_ENTRIES;
    assign pos_ok    = int'(wr.position) < MAX_NAME_LEN;
    assign in_prefix = int'(wr.position) < PREFIX_BYTES;
    assign nm_we     = wr.load && entry_ok && pos_ok;
    assign bm_we     = nm_we && in_prefix;

    always_comb
    begin
        for (int p = 0; p < PREFIX_BYTES; p++)
        begin
            for (int e = 0; e < MAX_ENTRIES; e++)
            begin
                bm_wdata[p*MAX_ENTRIES+e] = bm_row[p*MAX_ENTRIES+e] ||
                    ((int'(wr.position) == p) && (int'(wr.entry) == e));
            end
        end
        for (int e = 0; e < MAX_ENTRIES; e++)
        begin
            nm_wdata[e*BYTE_W +: BYTE_W] = (int'(wr.entry) == e) ?
                wr.data_byte : nm_row[e*BYTE_W +: BYTE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bm_valid_reg <= '0;
            name_len_reg <= '0;
        end
        else if (wr.clear)
        begin
            bm_valid_reg <= '0;
            name_len_reg <= '0;
        end
        else
        begin
            if (bm_we)
            begin
                bm_valid_reg[wr.data_byte] <= 1'b1;
            end
            if (nm_we && wr.last)
            begin
                name_len_reg[wr.entry] <= LEN_W'(wr.position) + len_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.rd_en)
        begin
            bm_addr_reg <= rd.bm_addr;
        end
    end

    bpfm_ram #(
        .WIDTH (BM_ROW_W),
        .DEPTH (BYTE_VALUES)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (wr.data_byte),
        .wdata (bm_wdata),
        .re    (rd.rd_en),
        .raddr (rd.bm_addr),
        .rdata (bm_rdata)
    );

    bpfm_ram #(
        .WIDTH (NM_ROW_W),
        .DEPTH (MAX_NAME_LEN)
    ) u_name_ram (
        .clk   (clk),
        .we    (nm_we),
        .waddr (NM_AW'(wr.position)),
        .wdata (nm_wdata),
        .re    (rd.rd_en),
        .raddr (rd.nm_addr),
        .rdata (nm_row)
    );

endmodule

[rtl/core/bitmap_prefix_field_match.sv]
// A key byte carrying last has its memory rows read, then its result registered as output;
// it waits only while the previous result is unread. A load or key byte occupies the block
// for a memory read, then modify and write back; a clear is applied when it is accepted.
// Reset: rst_n clears the bitmap row valid bits, name lengths and key state at once;
// no clearing pass is needed and the block takes items from the first cycle.
module bitmap_prefix_field_match
    import bpfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bpfm_in_if.sink     key_in,
    bpfm_out_if.source  result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 state_reg;
    func_t                func_reg;
    logic [ENTRY_W-1:0]   entry_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic                 last_reg;
    mask_t                mask_reg;
    mask_t                mask_next;
    len_t                 key_len_reg;
    len_t                 key_len_next;
    logic                 out_valid_reg;
    logic                 found_reg;
    logic                 found_next;
    logic [ENTRY_W-1:0]   index_reg;
    logic [ENTRY_W-1:0]   index_next;

    logic                 accept;
    logic                 need_out;
    logic                 stall;
    logic                 go;
    store_rd_t            rd;
    store_wr_t            wr;
    logic [BM_ROW_W-1:0]  bm_row;
    logic [NM_ROW_W-1:0]  nm_row;
    len_t [MAX_ENTRIES-1:0] name_len;

    assign key_in.ready = (state_reg == ST_IDLE);
    assign accept       = key_in.valid && key_in.ready;

    assign need_out = (func_reg == FUNC_KEY) && last_reg;
    assign stall    = need_out && out_valid_reg && !result.ready;
    assign go       = (state_reg == ST_EXEC) && !stall;

    assign rd.rd_en   = accept && ((key_in.func == FUNC_LOAD) || (key_in.func == FUNC_KEY));
    assign rd.bm_addr = key_in.data_byte;
    assign rd.nm_addr = (key_in.func == FUNC_LOAD) ? NM_AW'(key_in.position)
                                                   : NM_AW'(key_len_reg);

    assign wr.clear     = accept && (key_in.func == FUNC_CLEAR);
    assign wr.load      = go && (func_reg == FUNC_LOAD);
    assign wr.entry     = entry_reg;
    assign wr.position  = pos_reg;
    assign wr.data_byte = byte_reg;
    assign wr.last      = last_reg;

    bpfm_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .wr       (wr),
        .bm_row   (bm_row),
        .nm_row   (nm_row),
        .name_len (name_len)
    );

    // Narrow candidates by prefix bitmap or byte compare; past MAX_NAME_LEN clear them all.
    always_comb
    begin
        mask_next = mask_reg;
        if (int'(key_len_reg) < PREFIX_BYTES)
        begin
            for (int p = 0; p < PREFIX_BYTES; p++)
            begin
                if (int'(key_len_reg) == p)
                begin
                    mask_next = mask_reg & bm_row[p*MAX_ENTRIES +: MAX_ENTRIES];
                end
            end
        end
        else if (int'(key_len_reg) < MAX_NAME_LEN)
        begin
            for (int e = 0; e < MAX_ENTRIES; e++)
            begin
                if (nm_row[e*BYTE_W +: BYTE_W] != byte_reg)
                begin
                    mask_next[e] = 1'b0;
                end
            end
        end
        else
        begin
            mask_next = '0;
        end

        key_len_next = (int'(key_len_reg) < KEY_LEN_MAX) ? key_len_reg + len_t'(1)
                                                         : key_len_reg;

        // Walk from the top so the lowest matching entry wins.
        found_next = 1'b0;
        index_next = '0;
        for (int e = MAX_ENTRIES - 1; e >= 0; e--)
        begin
            if (mask_next[e] && (name_len[e] != '0) && (name_len[e] == key_len_next))
            begin
                found_next = 1'b1;
                index_next = ENTRY_W'(e);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '1;
            key_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (wr.clear)
                    begin
                        mask_reg    <= '1;
                        key_len_reg <= '0;
                    end
                    else if (rd.rd_en)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (go)
                    begin
                        state_reg <= ST_IDLE;
                        if (func_reg == FUNC_KEY)
                        begin
                            if (last_reg)
                            begin
                                mask_reg    <= '1;
                                key_len_reg <= '0;
                            end
                            else
                            begin
                                mask_reg    <= mask_next;
                                key_len_reg <= key_len_next;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (go && need_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= key_in.func;
            entry_reg <= key_in.entry;
            pos_reg   <= key_in.position;
            byte_reg  <= key_in.data_byte;
            last_reg  <= key_in.last;
        end
        if (go && need_out)
        begin
            found_reg <= found_next;
            index_reg <= index_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.found       = found_reg;
    assign result.field_index = index_reg;

endmodule

[rtl/core/bpfm_checker.sv]
module bpfm_checker
    import bpfm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [FUNC_W-1:0]  in_func,
    input  logic               in_last,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               out_found,
    input  logic [ENTRY_W-1:0] out_index
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // A stalled result stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_index))
        else $error("result changed while stalled");

    // A load or key byte makes the block busy after its transfer, for its read-modify-write.
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && ((in_func == FUNC_LOAD) || (in_func == FUNC_KEY)) |=> !in_ready)
        else $error("input taken during a read-modify-write");

    // A clear completes in its own cycle.
    a_clear_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_func == FUNC_CLEAR) |=> in_ready)
        else $error("clear held the input");

    // A fresh result only follows a final key byte that was transferred earlier.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_xfer && (in_func == FUNC_KEY) && in_last, 2))
        else $error("result without a final key byte");

endmodule

bind bitmap_prefix_field_match bpfm_checker u_bpfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (key_in.valid),
    .in_ready  (key_in.ready),
    .in_func   (key_in.func),
    .in_last   (key_in.last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_found (result.found),
    .out_index (result.field_index)
);

[tb/tb_bitmap_prefix_field_match.sv]
`timescale 1ns / 100ps

module tb_bitmap_prefix_field_match;
    import bpfm_pkg::*;

    localparam func_t FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1200;
    localparam int REPORT_LIMIT = 50;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    typedef struct packed {
        func_t              func;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   position;
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [ENTRY_W-1:0] index;
    } match_t;

    typedef enum {RX_OPEN, RX_THIRDS, RX_COIN, RX_SPARSE} rx_mode_t;

    class field_match_scoreboard;
        mask_t             prefix_map [PREFIX_BYTES][BYTE_VALUES];
        logic [BYTE_W-1:0] stored [MAX_ENTRIES][MAX_NAME_LEN];
        len_t              stored_len [MAX_ENTRIES];
        mask_t             live;
        len_t              key_len;
        match_t            expected[$];
        int                errors;
        int                results;

        function new();
            foreach (stored[e, p])
                stored[e][p] = '0;
            wipe();
            errors = 0;
            results = 0;
        endfunction

        function void wipe();
            foreach (prefix_map[p, b])
                prefix_map[p][b] = '0;
            foreach (stored_len[e])
                stored_len[e] = '0;
            live = '1;
            key_len = '0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function byte_q_t stored_name(int e);
            byte_q_t q;
            int p;
            q = {};
            for (p = 0; p < int'(stored_len[e]); p++)
                q.push_back(stored[e][p]);
            return q;
        endfunction

        // Advances the table and key state by one accepted input transfer.
        function void note_input(in_item_t it);
            int k;
            int e;
            match_t m;
            case (it.func)
                FUNC_CLEAR: wipe();
                FUNC_LOAD:
                begin
                    if (int'(it.entry) < MAX_ENTRIES && int'(it.position) < MAX_NAME_LEN)
                    begin
                        stored[it.entry][it.position] = it.data_byte;
                        if (int'(it.position) < PREFIX_BYTES)
                            prefix_map[it.position][it.data_byte][it.entry] = 1'b1;
                        if (it.last)
                            stored_len[it.entry] = len_t'(int'(it.position) + 1);
                    end
                end
                FUNC_KEY:
                begin
                    k = int'(key_len);
                    if (k < PREFIX_BYTES)
                        live &= prefix_map[k][it.data_byte];
                    else if (k < MAX_NAME_LEN)
                    begin
                        for (e = 0; e < MAX_ENTRIES; e++)
                            if (stored[e][k] != it.data_byte)
                                live[e] = 1'b0;
                    end
                    else
                        live = '0;
                    if (k < KEY_LEN_MAX)
                        key_len = key_len + 1'b1;
                    if (it.last)
                    begin
                        m = '0;
                        // Walk downward so the lowest matching entry is the one kept.
                        for (e = MAX_ENTRIES - 1; e >= 0; e--)
                            if (live[e] && stored_len[e] != 0 && stored_len[e] == key_len)
                            begin
                                m.found = 1'b1;
                                m.index = e[ENTRY_W-1:0];
                            end
                        expected.push_back(m);
                        live = '1;
                        key_len = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mismatch at result %0d: %s", results, msg);
        endtask

        task check_result(logic found, logic [ENTRY_W-1:0] index);
            match_t want;
            results++;
            if (expected.size() == 0)
            begin
                report_mismatch($sformatf("no key pending, got found=%0b index=%0d",
                                          found, index));
                return;
            end
            want = expected.pop_front();
            if (found !== want.found)
                report_mismatch($sformatf("found %0b, want %0b", found, want.found));
            if (index !== want.index)
                report_mismatch($sformatf("field_index %0d, want %0d", index, want.index));
        endtask
    endclass

    logic clk;
    logic rst_n;

    bpfm_in_if  key_ch ();
    bpfm_out_if res_ch ();

    bitmap_prefix_field_match dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_in (key_ch),
        .result (res_ch)
    );

    field_match_scoreboard sb = new();

    int burst_left;
    int sent;
    bit steady;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic push(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            if (!steady)
            begin
                gap = $urandom_range(1, 6);
                key_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        key_ch.valid     <= 1'b1;
        key_ch.func      <= it.func;
        key_ch.entry     <= it.entry;
        key_ch.position  <= it.position;
        key_ch.data_byte <= it.data_byte;
        key_ch.last      <= it.last;
        @(posedge clk);
        while (!key_ch.ready)
            @(posedge clk);
        sb.note_input(it);
        if (it.func != FUNC_UNUSED)
            sent++;
    endtask

    // Holds the sender off until every pending key has answered.
    task automatic drain();
        key_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 1) == 0)
            return 8'h61 + BYTE_W'($urandom_range(0, 3));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic int random_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 12);
        if (r < 95)
            return $urandom_range(13, 40);
        return $urandom_range(41, MAX_NAME_LEN);
    endfunction

    function automatic byte_q_t random_name(int len);
        byte_q_t q;
        q = {};
        repeat (len) q.push_back(pick_byte());
        return q;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            it.func = FUNC_CLEAR;
        else if (r < 40)
            it.func = FUNC_LOAD;
        else if (r < 80)
            it.func = FUNC_KEY;
        else
            it.func = FUNC_UNUSED;
        it.entry     = ENTRY_W'($urandom_range(0, MAX_ENTRIES - 1));
        it.position  = POS_W'($urandom_range(0, MAX_NAME_LEN - 1));
        it.data_byte = BYTE_W'($urandom_range(0, 255));
        it.last      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_clear();
        in_item_t it;
        it = random_item();
        it.func = FUNC_CLEAR;
        push(it);
    endtask

    task automatic load_name(input int e, input byte_q_t q, input bit with_last,
                             input bit backwards);
        in_item_t it;
        int i;
        int p;
        for (i = 0; i < q.size(); i++)
        begin
            p = backwards ? q.size() - 1 - i : i;
            it.func      = FUNC_LOAD;
            it.entry     = ENTRY_W'(e);
            it.position  = POS_W'(p);
            it.data_byte = q[p];
            it.last      = with_last && (p == q.size() - 1);
            push(it);
        end
    endtask

    task automatic send_key(input byte_q_t q, input bit interrupted);
        in_item_t it;
        int i;
        int cut;
        cut = $urandom_range(0, q.size() - 1);
        for (i = 0; i < q.size(); i++)
        begin
            // A load or an unused code in the middle of a key must not disturb it.
            if (interrupted && i == cut && i != 0)
            begin
                it = random_item();
                if (it.func != FUNC_LOAD)
                    it.func = FUNC_UNUSED;
                push(it);
            end
            it = random_item();
            it.func      = FUNC_KEY;
            it.data_byte = q[i];
            it.last      = (i == q.size() - 1);
            push(it);
        end
    endtask

    task automatic load_table();
        byte_q_t q;
        int n;
        int i;
        int e;
        int r;
        send_clear();
        n = $urandom_range(1, MAX_ENTRIES);
        for (i = 0; i < n; i++)
        begin
            e = $urandom_range(0, MAX_ENTRIES - 1);
            q = sb.stored_name($urandom_range(0, MAX_ENTRIES - 1));
            r = $urandom_range(0, 99);
            if (q.size() == 0 || r < 55)
                q = random_name(random_len());
            else if (r < 70)
                q[q.size() - 1] = pick_byte();
            else if (r < 85 && q.size() < MAX_NAME_LEN)
                q.push_back(pick_byte());
            else if (q.size() > 1)
                void'(q.pop_back());
            load_name(e, q, 1'b1, $urandom_range(0, 4) == 0);
        end
    endtask

    task automatic key_scene();
        byte_q_t q;
        int r;
        int target;
        int pos;
        q = sb.stored_name($urandom_range(0, MAX_ENTRIES - 1));
        if (q.size() == 0)
            q = random_name(random_len());
        r = $urandom_range(0, 99);
        if (r < 55)
            ;
        else if (r < 65)
        begin
            pos = $urandom_range(0, q.size() - 1);
            q[pos][$urandom_range(0, BYTE_W - 1)] ^= 1'b1;
        end
        else if (r < 73 && q.size() > 1)
            void'(q.pop_back());
        else if (r < 81)
            q.push_back(pick_byte());
        else if (r < 86)
        begin
            // Keys past the longest name, some long enough to saturate the length.
            target = $urandom_range(MAX_NAME_LEN + 1, 130);
            while (q.size() < target)
                q.push_back(pick_byte());
        end
        else
            q = random_name(random_len());
        send_key(q, $urandom_range(0, 19) == 0);
    endtask

    initial
    begin : result_sink
        rx_mode_t mode;
        int span;
        int phase;
        res_ch.ready <= 1'b0;
        mode = RX_OPEN;
        span = 0;
        phase = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.found, res_ch.field_index);
            if (span == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(16, 160);
            end
            span--;
            phase++;
            case (mode)
                RX_OPEN:   res_ch.ready <= 1'b1;
                RX_THIRDS: res_ch.ready <= (phase % 3) == 0;
                RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                default:   res_ch.ready <= (phase % 24) == 23;
            endcase
        end
    end

    initial
    begin : stimulus
        byte_q_t q;
        in_item_t it;
        int e;
        int p;
        int r;
        rst_n            <= 1'b0;
        key_ch.valid     <= 1'b0;
        key_ch.func      <= FUNC_CLEAR;
        key_ch.entry     <= '0;
        key_ch.position  <= '0;
        key_ch.data_byte <= '0;
        key_ch.last      <= 1'b0;
        burst_left = 0;
        sent = 0;
        steady = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Every name byte is written once up front, so later compares beyond the
        // prefix never read a byte that was never loaded.
        for (e = 0; e < MAX_ENTRIES; e++)
            for (p = 0; p < MAX_NAME_LEN; p++)
            begin
                it.func      = FUNC_LOAD;
                it.entry     = ENTRY_W'(e);
                it.position  = POS_W'(p);
                it.data_byte = BYTE_W'($urandom_range(0, 255));
                it.last      = 1'b0;
                push(it);
            end
        send_clear();

        // Directed: duplicate names resolve to the lowest entry, a name that runs
        // past the prefix, a partial name, an unused code, and a byte never loaded.
        q = {8'h61};
        load_name(0, q, 1'b1, 1'b0);
        load_name(1, q, 1'b1, 1'b0);
        q = {};
        repeat (10) q.push_back(8'hFF);
        load_name(MAX_ENTRIES - 1, q, 1'b1, 1'b0);
        q = {8'h62};
        load_name(2, q, 1'b0, 1'b0);
        it = random_item();
        it.func = FUNC_UNUSED;
        push(it);
        q = {8'h61};
        send_key(q, 1'b0);
        q = {8'h62};
        send_key(q, 1'b0);
        q = {};
        repeat (10) q.push_back(8'hFF);
        send_key(q, 1'b0);
        q = {8'h00};
        send_key(q, 1'b0);
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 8)
                load_table();
            else if (r < 14)
            begin
                // Reload without a clear: prefix bits pile up, bytes are replaced.
                q = random_name(random_len());
                load_name($urandom_range(0, MAX_ENTRIES - 1), q, 1'b1, 1'b0);
            end
            else if (r < 18)
            begin
                q = random_name(random_len());
                load_name($urandom_range(0, MAX_ENTRIES - 1), q, 1'b0, 1'b0);
            end
            else if (r < 80)
                repeat ($urandom_range(1, 6)) key_scene();
            else if (r < 95)
                repeat ($urandom_range(1, 8)) push(random_item());
            else
                drain();
        end

        key_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bpfm_pkg.sv
rtl/core/bpfm_in_if.sv
rtl/core/bpfm_out_if.sv
rtl/core/bpfm_ram.sv
rtl/core/bpfm_store.sv
rtl/core/bitmap_prefix_field_match.sv
rtl/core/bpfm_checker.sv
tb/tb_bitmap_prefix_field_match.sv
